// ===== hdl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon test
// Holds the request codes, the fixed field widths and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Fixed field widths
    localparam int IDX_W       = 6;
    localparam int CFG_W       = 7;
    localparam int OUT_TDATA_W = 8;

    // Vertex count after reset
    localparam logic [CFG_W-1:0] COUNT_RESET = 7'd3;

    // Request kinds carried on tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_en;     // write the vertex of the accepted request
        logic start;     // latch the query point, clear the parity
        logic rd_en;     // read one vertex from the store
        logic rd_edge;   // this read closes an edge with the previous vertex
        logic load_out;  // move the parity into the output register
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic busy;      // edge pipeline still holds work
    } dp_status_t;

endpackage

// ===== hdl/pip_datapath.sv =====
// ----------------------------------------------------------------------------
// pip_datapath: vertex store and edge crossing pipeline
// Stores the polygon corners, walks the edges that the controller reads out
// and keeps the crossing parity. Each edge passes a read stage, a product
// stage and a compare stage.
// ----------------------------------------------------------------------------
module pip_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pip_pkg::ctrl_cmd_t             cmd,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [AW-1:0]                  rd_addr,
    input  logic signed [COORD_WIDTH-1:0]  coord_x,
    input  logic signed [COORD_WIDTH-1:0]  coord_y,
    output pip_pkg::dp_status_t            sts,
    output logic [pip_pkg::OUT_TDATA_W-1:0] out_data
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW + 2;

    // Vertex store: y in the upper half, x in the lower half
    logic [2*CW-1:0] mem [MAX_VERTICES];
    logic [2*CW-1:0] rdata_reg;

    // Query point and previous vertex
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;

    // Pipeline control
    logic rd_v_reg, rd_edge_reg, s1_v_reg;
    logic parity_reg, parity_next;

    // Product stage
    logic signed [CW-1:0] x1, y1, x2, y2;
    logic signed [CW-1:0] ymin, ymax, xmax;
    logic signed [CW:0]   dy, ex, ddx, ddy;
    logic signed [PW-1:0] p_next, q_next, p_reg, q_reg;
    logic                 span_next, vert_next, up_next;
    logic                 span_reg, vert_reg, up_reg;
    logic                 crosses;
    logic [pip_pkg::OUT_TDATA_W-1:0] out_reg;

    // Store writes and registered reads
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= {coord_y, coord_x};
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Edge geometry from previous and current vertex
    always_comb begin
        x1   = prev_x_reg;
        y1   = prev_y_reg;
        x2   = rdata_reg[CW-1:0];
        y2   = rdata_reg[2*CW-1:CW];
        ymin = (y1 < y2) ? y1 : y2;
        ymax = (y1 < y2) ? y2 : y1;
        xmax = (x1 < x2) ? x2 : x1;
        dy   = {y2[CW-1], y2} - {y1[CW-1], y1};
        ex   = {x2[CW-1], x2} - {x1[CW-1], x1};
        ddx  = {px_reg[CW-1], px_reg} - {x1[CW-1], x1};
        ddy  = {py_reg[CW-1], py_reg} - {y1[CW-1], y1};
        p_next    = ddx * dy;
        q_next    = ddy * ex;
        span_next = (py_reg > ymin) && (py_reg <= ymax) && !(px_reg > xmax);
        vert_next = (x1 == x2);
        up_next   = (dy > 0);
    end

    // Crossing test: keep the compare for rising edges, reverse it for falling
    always_comb begin
        crosses     = span_reg && (vert_reg || (up_reg ? (p_reg <= q_reg)
                                                       : (p_reg >= q_reg)));
        parity_next = parity_reg;
        if (cmd.start) begin
            parity_next = 1'b0;
        end else if (s1_v_reg && crosses) begin
            parity_next = ~parity_reg;
        end
    end

    // Advance payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_v_reg) begin
            prev_x_reg <= x2;
            prev_y_reg <= y2;
        end
        p_reg    <= p_next;
        q_reg    <= q_next;
        span_reg <= span_next;
        vert_reg <= vert_next;
        up_reg   <= up_next;
        if (cmd.load_out) begin
            out_reg <= {{(pip_pkg::OUT_TDATA_W-1){1'b0}}, parity_reg};
        end
    end

    // Advance pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg    <= 1'b0;
            rd_edge_reg <= 1'b0;
            s1_v_reg    <= 1'b0;
            parity_reg  <= 1'b0;
        end else begin
            rd_v_reg    <= cmd.rd_en;
            rd_edge_reg <= cmd.rd_edge;
            s1_v_reg    <= rd_v_reg && rd_edge_reg;
            parity_reg  <= parity_next;
        end
    end

    assign sts.busy = rd_v_reg || s1_v_reg;
    assign out_data = out_reg;

endmodule

// ===== hdl/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pip_ctrl: request sequencer of the point-in-polygon test
// Accepts requests, holds the vertex count register, issues one vertex read
// per cycle for a query and owns the result handshake.
// ----------------------------------------------------------------------------
module pip_ctrl #(
    parameter int MAX_VERTICES = 64,
    parameter int AW           = $clog2(MAX_VERTICES),
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       req_type,
    input  logic [pip_pkg::IDX_W-1:0]  vertex_index,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pip_pkg::CFG_W-1:0]  cfg_data,
    input  pip_pkg::dp_status_t        sts,
    output pip_pkg::ctrl_cmd_t         cmd,
    output logic [AW-1:0]              wr_addr,
    output logic [AW-1:0]              rd_addr
);

    pip_pkg::state_t state_reg, state_next;
    logic [pip_pkg::CFG_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lim_reg, lim_next, rd_cnt_reg, rd_cnt_next, count_eff;
    logic m_tvalid_reg, m_tvalid_next;
    logic accept, last_rd, out_free;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == pip_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_rd   = (rd_cnt_reg == lim_reg);
    assign wr_addr   = AW'(vertex_index);
    assign rd_addr   = last_rd ? '0 : rd_cnt_reg[AW-1:0];

    // Saturate the vertex count to the store depth
    always_comb begin
        if (32'(count_reg) > MAX_VERTICES) begin
            count_eff = CNT_W'(MAX_VERTICES);
        end else begin
            count_eff = CNT_W'(count_reg);
        end
    end

    // Sequence one request
    always_comb begin
        state_next    = state_reg;
        lim_next      = lim_reg;
        rd_cnt_next   = rd_cnt_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            pip_pkg::ST_IDLE: begin
                if (accept) begin
                    if (req_type == pip_pkg::REQ_WRITE) begin
                        cmd.wr_en = (32'(vertex_index) < MAX_VERTICES);
                    end else begin
                        cmd.start   = 1'b1;
                        lim_next    = count_eff;
                        rd_cnt_next = '0;
                        state_next  = (count_eff == '0) ? pip_pkg::ST_DRAIN
                                                        : pip_pkg::ST_LOAD;
                    end
                end
            end
            pip_pkg::ST_LOAD: begin
                // Read vertices 0..n-1, then vertex 0 again for the closing edge
                cmd.rd_en   = 1'b1;
                cmd.rd_edge = (rd_cnt_reg != '0);
                if (last_rd) begin
                    state_next = pip_pkg::ST_DRAIN;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
            end
            pip_pkg::ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = pip_pkg::ST_DONE;
                end
            end
            pip_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pip_pkg::ST_IDLE;
            count_reg    <= pip_pkg::COUNT_RESET;
            lim_reg      <= '0;
            rd_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            lim_reg      <= lim_next;
            rd_cnt_reg   <= rd_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result is only taken once the edge pipeline has emptied
    a_done_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pip_pkg::ST_DONE) |-> !sts.busy)
        else $error("result stage reached with edges in flight");

    // Read counter never passes the captured vertex count
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pip_pkg::ST_LOAD) |-> (rd_cnt_reg <= lim_reg))
        else $error("vertex read counter overran");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("pending result overwritten");

    // A query always leaves the idle state
    a_query_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (req_type == pip_pkg::REQ_QUERY))
            |=> (state_reg != pip_pkg::ST_IDLE))
        else $error("query accepted without being run");

endmodule

// ===== hdl/point_in_polygon_test.sv =====
// Requests are accepted only in the idle state, so a query must finish and load its
// result before the next request is taken; writes are taken one per cycle while idle.
// The store's single read port walks one edge per cycle; a result held off by m_tready
// keeps the next query from loading its own. Reset (aresetn low at a clock edge)
// clears control state and sets the vertex count to 3; the vertex store is not cleared
// and must be written before a query reads it.
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon test
// Vertex writes fill a store of polygon corners; a query walks every edge,
// including the closing one, and reports the crossing parity.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // Request channel
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // tdata from bit 0: vertex_index[5:0], coord_x, coord_y, zero padding
    input  logic [((pip_pkg::IDX_W + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: req_type
    input  logic [0:0]                                s_tuser,
    // Result channel
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // tdata from bit 0: inside_res, zero padding
    output logic [pip_pkg::OUT_TDATA_W-1:0]           m_tdata,
    // Vertex count register
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [pip_pkg::CFG_W-1:0]                 cfg_data
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int XLO   = pip_pkg::IDX_W;
    localparam int YLO   = pip_pkg::IDX_W + COORD_WIDTH;

    pip_pkg::ctrl_cmd_t  cmd;
    pip_pkg::dp_status_t sts;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic signed [COORD_WIDTH-1:0] coord_x, coord_y;

    // Unpack the request fields
    assign coord_x = s_tdata[XLO +: COORD_WIDTH];
    assign coord_y = s_tdata[YLO +: COORD_WIDTH];

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req_type     (s_tuser[0]),
        .vertex_index (s_tdata[pip_pkg::IDX_W-1:0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .sts          (sts),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH),
        .AW           (AW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule
